// ===== hdl/x86enc_pkg.sv =====
// shared types and constants for the x86-64 memory operand encoder
// no dependencies; imported by every module of the block

package x86enc_pkg;

   localparam int MaxBytes = 9;
   localparam int LenW     = 4;

   // action codes
   localparam logic [1:0] ACT_STORE = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_MOVZX = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   // encoding bytes
   localparam logic [7:0] REX_W       = 8'h48;
   localparam logic [7:0] REX_R       = 8'h04;
   localparam logic [7:0] REX_B       = 8'h01;
   localparam logic [7:0] MOD_DISP8   = 8'h40;
   localparam logic [7:0] MOD_DISP32  = 8'h80;
   localparam logic [7:0] SIB_NOINDEX = 8'h24;
   localparam logic [7:0] OP_STORE    = 8'h89;
   localparam logic [7:0] OP_LOAD     = 8'h8B;
   localparam logic [7:0] OP_ESC      = 8'h0F;
   localparam logic [7:0] OP_MOVZX    = 8'hB7;
   localparam logic [2:0] RM_SIB      = 3'd4;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  data_reg;
      logic [3:0]  base_reg;
      logic [31:0] displacement;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // one classified instruction waiting for serialisation
   typedef struct packed {
      logic [0:MaxBytes-1][7:0] bytes;
      logic [LenW-1:0]          len;
   } instr_type;

endpackage

// ===== hdl/x86enc_front.sv =====
// front end: takes a request and builds the complete byte image of the instruction
// depends on x86enc_pkg

module x86enc_front
   import x86enc_pkg::*;
(
   input  logic      accept,
   input  req_type   req,
   output logic      push,
   output instr_type instr
);

   logic            short_disp;
   logic [LenW-1:0] pos;
   logic [7:0]      rex;
   logic [7:0]      modrm;

   // fits in a signed byte when bits 31..7 are all equal
   assign short_disp = (req.displacement[31:7] == '0) || (req.displacement[31:7] == '1);

   assign push = accept && (req.action != ACT_NONE);

   always_comb begin
      rex   = REX_W | (req.data_reg[3] ? REX_R : 8'h00) | (req.base_reg[3] ? REX_B : 8'h00);
      modrm = (short_disp ? MOD_DISP8 : MOD_DISP32)
              | {2'b00, req.data_reg[2:0], req.base_reg[2:0]};
      instr.bytes = '0;
      instr.bytes[0] = rex;
      pos = LenW'(1);
      unique case (req.action)
         ACT_STORE: begin
            instr.bytes[pos] = OP_STORE;
            pos = pos + LenW'(1);
         end
         ACT_LOAD: begin
            instr.bytes[pos] = OP_LOAD;
            pos = pos + LenW'(1);
         end
         default: begin
            instr.bytes[pos] = OP_ESC;
            instr.bytes[pos + LenW'(1)] = OP_MOVZX;
            pos = pos + LenW'(2);
         end
      endcase
      instr.bytes[pos] = modrm;
      pos = pos + LenW'(1);
      if (req.base_reg[2:0] == RM_SIB) begin
         instr.bytes[pos] = SIB_NOINDEX;
         pos = pos + LenW'(1);
      end
      if (short_disp) begin
         instr.bytes[pos] = req.displacement[7:0];
         pos = pos + LenW'(1);
      end else begin
         instr.bytes[pos]             = req.displacement[7:0];
         instr.bytes[pos + LenW'(1)]  = req.displacement[15:8];
         instr.bytes[pos + LenW'(2)]  = req.displacement[23:16];
         instr.bytes[pos + LenW'(3)]  = req.displacement[31:24];
         pos = pos + LenW'(4);
      end
      instr.len = pos;
   end

endmodule

// ===== hdl/x86enc_queue.sv =====
// small fifo of classified instructions between front and back end
// depends on x86enc_pkg

module x86enc_queue
   import x86enc_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  instr_type push_data,
   input  logic      pop,
   output instr_type pop_data,
   output logic      empty,
   output logic      full
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   instr_type           storage_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CntW'(DEPTH));
   assign pop_data = storage_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         storage_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/x86enc_back.sv =====
// back end: serialises one queued instruction a byte per cycle onto the result port
// depends on x86enc_pkg

module x86enc_back
   import x86enc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      empty,
   input  instr_type head,
   output logic      pop,
   output logic      rsp_strobe,
   output rsp_type   rsp_payload
);

   instr_type       cur_ff, cur_in;
   logic [LenW-1:0] idx_ff, idx_in;
   logic            active_ff, active_in;
   logic            strobe_ff, strobe_in;
   rsp_type         payload_ff, payload_in;
   logic            at_last;

   assign at_last = active_ff && (idx_ff == cur_ff.len - LenW'(1));
   // next instruction is loaded on the final byte so instructions run back to back
   assign pop     = !empty && (!active_ff || at_last);

   always_comb begin
      cur_in     = cur_ff;
      idx_in     = idx_ff;
      active_in  = active_ff;
      strobe_in  = active_ff;
      payload_in = payload_ff;
      if (active_ff) begin
         payload_in.out_byte = cur_ff.bytes[idx_ff];
         payload_in.last     = at_last;
         idx_in              = idx_ff + LenW'(1);
      end
      if (pop) begin
         cur_in    = head;
         idx_in    = '0;
         active_in = 1'b1;
      end else if (at_last) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      payload_ff <= payload_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = payload_ff;

endmodule

// ===== hdl/x86_64_memory_operand_encoder_top.sv =====
// top level of the x86-64 memory operand encoder
// depends on x86enc_pkg, x86enc_front, x86enc_queue and x86enc_back

// A request (action, data register, base register, displacement) is taken at a
// clock edge where start is high and busy is low. It is encoded as REX.W, opcode,
// ModRM, optional SIB and an 8- or 32-bit displacement, and the bytes leave on
// rsp_payload one per cycle with rsp_strobe high, the final byte carrying last.
// The receiver cannot stall: every strobed byte must be taken in that cycle.
// An instruction is 4 to 9 bytes long, serialised by the byte-wide back end; the
// first byte passes through the queue, the back end's instruction register and
// its output register, and queued instructions leave without gaps. Requests
// queue in a QUEUE_DEPTH-entry fifo; busy is high while it is full. Action code 3
// is accepted and produces no bytes.

module x86_64_memory_operand_encoder_top
   import x86enc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   logic      accept;
   logic      push;
   logic      pop;
   logic      empty;
   logic      full;
   instr_type instr;
   instr_type head;

   assign busy   = full;
   assign accept = start && !busy;

   x86enc_front u_front (
      .accept (accept),
      .req    (req_payload),
      .push   (push),
      .instr  (instr)
   );

   x86enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (instr),
      .pop       (pop),
      .pop_data  (head),
      .empty     (empty),
      .full      (full)
   );

   x86enc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .empty       (empty),
      .head        (head),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== test/tb_x86_64_memory_operand_encoder_top.sv =====
// self-checking testbench for x86_64_memory_operand_encoder_top
// encodes each accepted request in a local model and checks every strobed byte
// depends on x86enc_pkg and the top level in hdl

module tb_x86_64_memory_operand_encoder_top;
   import x86enc_pkg::*;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   rsp_type encoded_bytes[$];
   int      mismatch_count = 0;

   x86_64_memory_operand_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("error at %0t: %s expected %h got %h", $time, what, want, got);
      mismatch_count++;
   endtask

   // builds the byte stream of one instruction and queues it
   function automatic void encode_instruction(input req_type r);
      logic [7:0] stream[$];
      logic [7:0] rex;
      logic       short_disp;
      rsp_type    b;
      if (r.action == ACT_NONE) return;
      rex = REX_W;
      if (r.data_reg[3]) rex = rex | REX_R;
      if (r.base_reg[3]) rex = rex | REX_B;
      stream.push_back(rex);
      case (r.action)
         ACT_STORE: stream.push_back(OP_STORE);
         ACT_LOAD:  stream.push_back(OP_LOAD);
         default: begin
            stream.push_back(OP_ESC);
            stream.push_back(OP_MOVZX);
         end
      endcase
      short_disp = ($signed(r.displacement) >= -128) && ($signed(r.displacement) <= 127);
      stream.push_back((short_disp ? MOD_DISP8 : MOD_DISP32)
                       | {2'b00, r.data_reg[2:0], r.base_reg[2:0]});
      if (r.base_reg[2:0] == RM_SIB) stream.push_back(SIB_NOINDEX);
      if (short_disp) begin
         stream.push_back(r.displacement[7:0]);
      end else begin
         for (int i = 0; i < 4; i++) stream.push_back(r.displacement[8*i +: 8]);
      end
      foreach (stream[i]) begin
         b.out_byte = stream[i];
         b.last     = (i == stream.size() - 1);
         encoded_bytes.push_back(b);
      end
   endfunction

   function automatic req_type make_request(input logic [1:0] action, input logic [3:0] dreg,
                                            input logic [3:0] breg, input logic [31:0] disp);
      req_type r;
      r.action       = action;
      r.data_reg     = dreg;
      r.base_reg     = breg;
      r.displacement = disp;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      r.action   = ($urandom_range(0, 99) < 6) ? ACT_NONE : 2'($urandom_range(0, 2));
      r.data_reg = 4'($urandom);
      // favour the stack-style bases now and then
      r.base_reg = ($urandom_range(0, 5) == 0) ? {1'($urandom), RM_SIB} : 4'($urandom);
      pick = $urandom_range(0, 5);
      case (pick)
         0, 1:    r.displacement = 32'($signed($urandom_range(0, 255)) - 128);
         2:       r.displacement = 32'($signed($urandom_range(0, 7)) + 124)
                                   * ($urandom_range(0, 1) ? 32'd1 : -32'd1);
         default: r.displacement = $urandom;
      endcase
      return r;
   endfunction

   // holds start until the transfer happens, then queues the expected bytes
   task automatic send_request(input req_type r);
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      encode_instruction(r);
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic int random_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (encoded_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_forms();
      req_type list[$];
      list.push_back(make_request(ACT_STORE, 4'd0,  4'd0,  32'h0000_0000));
      list.push_back(make_request(ACT_LOAD,  4'd15, 4'd15, 32'hFFFF_FFFF));
      list.push_back(make_request(ACT_MOVZX, 4'd8,  4'd4,  32'h0000_007F));
      list.push_back(make_request(ACT_STORE, 4'd7,  4'd12, 32'hFFFF_FF80));
      list.push_back(make_request(ACT_LOAD,  4'd3,  4'd5,  32'h0000_0080));
      list.push_back(make_request(ACT_MOVZX, 4'd12, 4'd13, 32'hFFFF_FF7F));
      list.push_back(make_request(ACT_STORE, 4'd9,  4'd4,  32'h7FFF_FFFF));
      list.push_back(make_request(ACT_LOAD,  4'd4,  4'd12, 32'h8000_0000));
      list.push_back(make_request(ACT_MOVZX, 4'd15, 4'd0,  32'h1234_5678));
      list.push_back(make_request(ACT_STORE, 4'd2,  4'd8,  32'h0000_0000));
      list.push_back(make_request(ACT_LOAD,  4'd10, 4'd7,  32'hA5A5_5A5A));
      list.push_back(make_request(ACT_MOVZX, 4'd0,  4'd12, 32'h0000_0000));
      foreach (list[i]) begin
         send_request(list[i]);
         idle_for(i % 3);
      end
   endtask

   // unused action code accepted between real instructions
   task automatic test_unused_action();
      send_request(make_request(ACT_NONE, 4'd15, 4'd15, 32'hFFFF_FFFF));
      send_request(make_request(ACT_STORE, 4'd1, 4'd2, 32'h0000_0010));
      send_request(make_request(ACT_NONE, 4'd0, 4'd4, 32'h0000_0000));
      send_request(make_request(ACT_NONE, 4'd8, 4'd12, 32'h8000_0000));
      idle_for(5);
      send_request(make_request(ACT_MOVZX, 4'd11, 4'd12, 32'hFFFF_FF00));
      send_request(make_request(ACT_NONE, 4'd5, 4'd9, 32'h0000_0042));
   endtask

   task automatic test_drain_pause();
      repeat (6) send_request(random_request());
      wait_for_drain();
      repeat (6) send_request(random_request());
      wait_for_drain();
   endtask

   task automatic test_random_stream();
      bit back_to_back;
      back_to_back = 1'b0;
      for (int n = 0; n < 350; n++) begin
         // alternate stretches with and without sender gaps
         if (n % 50 == 0) back_to_back = ~back_to_back;
         send_request(random_request());
         if (!back_to_back) idle_for(random_gap());
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (encoded_bytes.size() == 0) begin
            report_mismatch("unexpected byte", 32'h0, {23'h0, rsp_payload});
         end else begin
            if (rsp_payload.out_byte !== encoded_bytes[0].out_byte)
               report_mismatch("out_byte", 32'(encoded_bytes[0].out_byte),
                               32'(rsp_payload.out_byte));
            if (rsp_payload.last !== encoded_bytes[0].last)
               report_mismatch("last", 32'(encoded_bytes[0].last), 32'(rsp_payload.last));
            void'(encoded_bytes.pop_front());
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_forms();
      test_unused_action();
      test_drain_pause();
      test_random_stream();
      wait_for_drain();
      // let any stray byte surface before the verdict
      repeat (20) @(posedge clock);
      if (encoded_bytes.size() != 0)
         report_mismatch("bytes never seen", 32'(encoded_bytes.size()), 32'h0);
      if (mismatch_count == 0) begin
         $display("x86_64_memory_operand_encoder_top: match");
      end else begin
         $display("x86_64_memory_operand_encoder_top: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("x86_64_memory_operand_encoder_top: mismatch");
      $finish;
   end

endmodule
